// ----- sv/skit_pkg.sv -----
// Shared constants, codes and types for the sorted key index table.
// Used by the channel interfaces, the entry cell and the top level.
package skit_pkg;

   // Table geometry and field widths
   localparam int TABLE_DEPTH = 256;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int TOTAL_W     = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 31;
   localparam int POS_W       = 31;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int SLOT_OUT_W  = 8;
   localparam int TOTAL_OUT_W = 9;

   // Request kinds
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // Command broadcast from the sequencer to every entry cell
   typedef struct packed {
      logic capture;     // compare the incoming key and hold the flags
      logic shift_up;    // open a gap at the lower slot and load the new entry
      logic shift_down;  // close the gap at the lower slot
   } cell_cmd_type;

endpackage

// ----- sv/skit_if.sv -----
// Request and response channel interfaces of the sorted key index table.
// Depends on skit_pkg for the field widths.
interface skit_req_if;
   logic                             valid;
   logic                             ready;
   logic [skit_pkg::OP_W-1:0]        opcode;
   logic [skit_pkg::KEY_W-1:0]       key;
   logic [skit_pkg::POS_W-1:0]       record_position;

   modport source (output valid, opcode, key, record_position, input ready);
   modport sink   (input valid, opcode, key, record_position, output ready);
endinterface

interface skit_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [skit_pkg::STATUS_W-1:0]    status;
   logic [skit_pkg::SLOT_OUT_W-1:0]  slot;
   logic [skit_pkg::POS_W-1:0]       found_position;
   logic [skit_pkg::TOTAL_OUT_W-1:0] entry_total;

   modport source (output valid, status, slot, found_position, entry_total, input ready);
   modport sink   (input valid, status, slot, found_position, entry_total, output ready);
endinterface

// ----- sv/skit_cell.sv -----
// One entry cell of the table: holds a key and record position, compares
// against the request key and trades its entry with its neighbors. Uses skit_pkg.
module skit_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  skit_pkg::cell_cmd_type      cmd,
   input  logic                        occupied,
   input  logic [skit_pkg::KEY_W-1:0]  cmp_key,
   input  logic [skit_pkg::KEY_W-1:0]  new_key,
   input  logic [skit_pkg::POS_W-1:0]  new_pos,
   input  logic                        prev_ge,
   input  logic [skit_pkg::KEY_W-1:0]  prev_key,
   input  logic [skit_pkg::POS_W-1:0]  prev_pos,
   input  logic [skit_pkg::KEY_W-1:0]  next_key,
   input  logic [skit_pkg::POS_W-1:0]  next_pos,
   output logic [skit_pkg::KEY_W-1:0]  key,
   output logic [skit_pkg::POS_W-1:0]  pos,
   output logic                        ge,
   output logic                        at,
   output logic                        hit
);

   logic [skit_pkg::KEY_W-1:0] key_ff, key_in;
   logic [skit_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       ge_ff, ge_in;
   logic                       eq_ff, eq_in;

   // Compare: an empty cell counts as at or past the lower slot
   always_comb begin
      ge_in = ge_ff;
      eq_in = eq_ff;
      if (cmd.capture) begin
         ge_in = !(occupied && (key_ff < cmp_key));
         eq_in = occupied && (key_ff == cmp_key);
      end
   end

   // Lower slot is the first cell that is at or past the key
   assign at  = ge_ff && !prev_ge;
   assign hit = at && eq_ff;

   // Shift: take from the lower neighbor, load the new entry, or take from above
   always_comb begin
      key_in = key_ff;
      pos_in = pos_ff;
      if (cmd.shift_up) begin
         if (prev_ge) begin
            key_in = prev_key;
            pos_in = prev_pos;
         end else if (ge_ff) begin
            key_in = new_key;
            pos_in = new_pos;
         end
      end else if (cmd.shift_down && ge_ff) begin
         key_in = next_key;
         pos_in = next_pos;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pos_ff <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ge_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         ge_ff <= ge_in;
         eq_ff <= eq_in;
      end
   end

   assign key = key_ff;
   assign pos = pos_ff;
   assign ge  = ge_ff;

endmodule

// ----- sv/sorted_key_index_table.sv -----
// Sorted key index table: up to 256 unique keys, each with a record position, kept
// in ascending order in a row of entry cells. Every request runs in two steps: in the
// accept cycle all cells compare the key at once and hold their flags; in the execute
// step the lower slot is picked from the flags, the result is written to the output
// register, and an insert or delete moves every affected cell by one place in that
// same step. A new request is taken while a result still waits; the execute cycle
// holds only if the previous result has not yet been taken. No clearing after reset.
module sorted_key_index_table (
   input  logic        clock,
   input  logic        reset,
   skit_req_if.sink    req_chan,
   skit_rsp_if.source  rsp_chan
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;

   logic [skit_pkg::OP_W-1:0]    op_ff;
   logic [skit_pkg::KEY_W-1:0]   key_ff;
   logic [skit_pkg::POS_W-1:0]   pos_ff;
   logic [skit_pkg::TOTAL_W-1:0] count_ff, count_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [skit_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [skit_pkg::SLOT_OUT_W-1:0]     slot_ff, slot_in;
   logic [skit_pkg::POS_W-1:0]          found_ff, found_in;
   logic [skit_pkg::TOTAL_OUT_W-1:0]    total_ff, total_in;

   skit_pkg::cell_cmd_type cmd;

   logic [skit_pkg::KEY_W-1:0] cell_key [skit_pkg::TABLE_DEPTH];
   logic [skit_pkg::POS_W-1:0] cell_pos [skit_pkg::TABLE_DEPTH];
   logic [skit_pkg::TABLE_DEPTH-1:0] cell_ge, cell_at, cell_hit;

   logic                          accept, out_free, finish, hit, full;
   logic [skit_pkg::SLOT_W-1:0]   at_slot;
   logic [skit_pkg::POS_W-1:0]    at_pos;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish   = (state_ff == ST_EXEC) && out_free;
   assign full     = (count_ff == skit_pkg::TOTAL_W'(skit_pkg::TABLE_DEPTH));

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Encode the lower slot and pick its record position
   always_comb begin
      at_slot = '0;
      at_pos  = '0;
      for (int i = 0; i < skit_pkg::TABLE_DEPTH; i++) begin
         if (cell_at[i]) begin
            at_slot = at_slot | skit_pkg::SLOT_W'(i);
            at_pos  = at_pos | cell_pos[i];
         end
      end
   end

   assign hit = |cell_hit;

   // Broadcast commands to the cells
   always_comb begin
      cmd.capture    = accept;
      cmd.shift_up   = finish && (op_ff == skit_pkg::OP_INSERT) && !hit && !full;
      cmd.shift_down = finish && (op_ff == skit_pkg::OP_DELETE) && hit;
   end

   // Row of entry cells
   for (genvar i = 0; i < skit_pkg::TABLE_DEPTH; i++) begin : g_cell
      logic                       prev_ge;
      logic [skit_pkg::KEY_W-1:0] prev_key, next_key;
      logic [skit_pkg::POS_W-1:0] prev_pos, next_pos;

      if (i == 0) begin : g_first
         assign prev_ge  = 1'b0;
         assign prev_key = cell_key[i];
         assign prev_pos = cell_pos[i];
      end else begin : g_mid
         assign prev_ge  = cell_ge[i-1];
         assign prev_key = cell_key[i-1];
         assign prev_pos = cell_pos[i-1];
      end

      if (i == skit_pkg::TABLE_DEPTH - 1) begin : g_last
         assign next_key = cell_key[i];
         assign next_pos = cell_pos[i];
      end else begin : g_low
         assign next_key = cell_key[i+1];
         assign next_pos = cell_pos[i+1];
      end

      skit_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .occupied (count_ff > skit_pkg::TOTAL_W'(i)),
         .cmp_key  (req_chan.key),
         .new_key  (key_ff),
         .new_pos  (pos_ff),
         .prev_ge  (prev_ge),
         .prev_key (prev_key),
         .prev_pos (prev_pos),
         .next_key (next_key),
         .next_pos (next_pos),
         .key      (cell_key[i]),
         .pos      (cell_pos[i]),
         .ge       (cell_ge[i]),
         .at       (cell_at[i]),
         .hit      (cell_hit[i])
      );
   end

   // Sequence: accept and compare, then execute and write the result
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Build the result and the next entry count
   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      found_in  = found_ff;
      total_in  = total_ff;
      if (finish) begin
         status_in = skit_pkg::ST_OK;
         slot_in   = '0;
         found_in  = '0;
         unique case (op_ff)
            skit_pkg::OP_LOOKUP: begin
               if (hit) begin
                  slot_in  = skit_pkg::SLOT_OUT_W'(at_slot);
                  found_in = at_pos;
               end else begin
                  status_in = skit_pkg::ST_NOT_FOUND;
               end
            end
            skit_pkg::OP_INSERT: begin
               if (hit) begin
                  status_in = skit_pkg::ST_DUPLICATE;
                  slot_in   = skit_pkg::SLOT_OUT_W'(at_slot);
               end else if (full) begin
                  status_in = skit_pkg::ST_FULL;
               end else begin
                  slot_in  = skit_pkg::SLOT_OUT_W'(at_slot);
                  count_in = count_ff + 1'b1;
               end
            end
            skit_pkg::OP_DELETE: begin
               if (hit) begin
                  slot_in  = skit_pkg::SLOT_OUT_W'(at_slot);
                  count_in = count_ff - 1'b1;
               end else begin
                  status_in = skit_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
            end
         endcase
         total_in = skit_pkg::TOTAL_OUT_W'(count_in);
      end
   end

   // Hold the response until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.opcode;
         key_ff <= req_chan.key;
         pos_ff <= req_chan.record_position;
      end
      status_ff <= status_in;
      slot_ff   <= slot_in;
      found_ff  <= found_in;
      total_ff  <= total_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.slot           = slot_ff;
   assign rsp_chan.found_position = found_ff;
   assign rsp_chan.entry_total    = total_ff;

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for sorted_key_index_table: directed and random request streams
// are checked against a shadow sorted table. Depends on skit_pkg and the channel
// interfaces in skit_if.sv.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [skit_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [skit_pkg::OP_W-1:0]  opcode;
      logic [skit_pkg::KEY_W-1:0] key;
      logic [skit_pkg::POS_W-1:0] position;
   } request_type;

   typedef struct packed {
      logic [skit_pkg::STATUS_W-1:0]    status;
      logic [skit_pkg::SLOT_OUT_W-1:0]  slot;
      logic [skit_pkg::POS_W-1:0]       found_position;
      logic [skit_pkg::TOTAL_OUT_W-1:0] entry_total;
   } result_type;

   logic clock;
   logic reset;

   skit_req_if req_if ();
   skit_rsp_if rsp_if ();

   sorted_key_index_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // Shadow copy of the sorted table
   logic [skit_pkg::KEY_W-1:0] tbl_keys [skit_pkg::TABLE_DEPTH];
   logic [skit_pkg::POS_W-1:0] tbl_positions [skit_pkg::TABLE_DEPTH];
   int                         tbl_count;

   request_type                request_queue [$];
   result_type                 pending_results [$];
   logic [skit_pkg::KEY_W-1:0] issued_keys [$];

   int  total_requests;
   int  accepted_count;
   int  result_count;
   int  fail_count;
   int  idle_cycles;
   int  burst_left;
   int  gap_left;
   int  stall_left;
   int  ready_mode;
   int  mode_cycles;
   int  insert_ok, insert_dup, insert_full, delete_ok, lookup_hit, miss_count, peak_count;
   logic req_taken;

   // Clock generation
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [30:0] rand31();
      logic [31:0] w;
      w = $urandom;
      return w[30:0];
   endfunction

   // Return a key that was sent with an insert (a random key if none is left); optionally take it out of the list
   function automatic logic [skit_pkg::KEY_W-1:0] pick_issued(bit take);
      int idx;
      logic [skit_pkg::KEY_W-1:0] k;
      if (issued_keys.size() == 0) return rand31();
      idx = $urandom_range(0, issued_keys.size() - 1);
      k = issued_keys[idx];
      if (take) issued_keys.delete(idx);
      return k;
   endfunction

   task automatic add_request(logic [skit_pkg::OP_W-1:0] op, logic [skit_pkg::KEY_W-1:0] k,
                              logic [skit_pkg::POS_W-1:0] p);
      request_type rq;
      rq.opcode = op;
      rq.key = k;
      rq.position = p;
      request_queue.push_back(rq);
      if (op == skit_pkg::OP_INSERT) issued_keys.push_back(k);
      total_requests++;
   endtask

   // Compute the result of one request and update the shadow table
   function automatic result_type predict_result(request_type rq);
      result_type r;
      int lo, hi, mid, i;
      bit hit;
      r = '0;
      lo = 0;
      hi = tbl_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (tbl_keys[mid] < rq.key) lo = mid + 1;
         else hi = mid;
      end
      hit = (lo < tbl_count) && (tbl_keys[lo] == rq.key);
      case (rq.opcode)
         skit_pkg::OP_LOOKUP: begin
            if (hit) begin
               r.slot = lo[skit_pkg::SLOT_OUT_W-1:0];
               r.found_position = tbl_positions[lo];
               lookup_hit++;
            end else begin
               r.status = skit_pkg::ST_NOT_FOUND;
               miss_count++;
            end
         end
         skit_pkg::OP_INSERT: begin
            if (hit) begin
               r.status = skit_pkg::ST_DUPLICATE;
               r.slot = lo[skit_pkg::SLOT_OUT_W-1:0];
               insert_dup++;
            end else if (tbl_count >= skit_pkg::TABLE_DEPTH) begin
               r.status = skit_pkg::ST_FULL;
               insert_full++;
            end else begin
               // open a gap at the ordered slot
               for (i = tbl_count; i > lo; i--) begin
                  tbl_keys[i] = tbl_keys[i-1];
                  tbl_positions[i] = tbl_positions[i-1];
               end
               tbl_keys[lo] = rq.key;
               tbl_positions[lo] = rq.position;
               tbl_count++;
               r.slot = lo[skit_pkg::SLOT_OUT_W-1:0];
               insert_ok++;
               if (tbl_count > peak_count) peak_count = tbl_count;
            end
         end
         skit_pkg::OP_DELETE: begin
            if (hit) begin
               // close the gap left by the removed entry
               for (i = lo; i + 1 < tbl_count; i++) begin
                  tbl_keys[i] = tbl_keys[i+1];
                  tbl_positions[i] = tbl_positions[i+1];
               end
               tbl_count--;
               r.slot = lo[skit_pkg::SLOT_OUT_W-1:0];
               delete_ok++;
            end else begin
               r.status = skit_pkg::ST_NOT_FOUND;
               miss_count++;
            end
         end
         default: begin
         end
      endcase
      r.entry_total = tbl_count[skit_pkg::TOTAL_OUT_W-1:0];
      return r;
   endfunction

   // Request driver: bursts of random length with random gaps
   always @(negedge clock) begin
      request_type rq;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (request_queue.size() > 0) begin
            rq = request_queue.pop_front();
            req_if.opcode <= rq.opcode;
            req_if.key <= rq.key;
            req_if.record_position <= rq.position;
            req_if.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: switch between always ready, random and long stalls
   always @(negedge clock) begin
      logic rdy;
      if (mode_cycles == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_cycles = $urandom_range(20, 80);
      end else begin
         mode_cycles--;
      end
      case (ready_mode)
         0: rdy = 1'b1;
         1: rdy = ($urandom_range(0, 1) == 1);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rdy = 1'b0;
            end else begin
               rdy = 1'b1;
               if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(3, 12);
            end
         end
      endcase
      rsp_if.ready <= rdy;
   end

   // Monitor and scoreboard
   always @(posedge clock) begin
      request_type rq;
      result_type got, want;
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            rq.opcode = req_if.opcode;
            rq.key = req_if.key;
            rq.position = req_if.record_position;
            pending_results.push_back(predict_result(rq));
            accepted_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.status = rsp_if.status;
            got.slot = rsp_if.slot;
            got.found_position = rsp_if.found_position;
            got.entry_total = rsp_if.entry_total;
            result_count++;
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("ERROR: unexpected result status=%0d slot=%0d pos=%0h total=%0d",
                           got.status, got.slot, got.found_position, got.entry_total);
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.found_position !== want.found_position ||
                   got.entry_total !== want.entry_total) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("ERROR: result %0d exp status=%0d slot=%0d pos=%0h total=%0d",
                              result_count, want.status, want.slot, want.found_position,
                              want.entry_total);
                     $display("       got status=%0d slot=%0d pos=%0h total=%0d",
                              got.status, got.slot, got.found_position, got.entry_total);
                  end
               end
            end
         end
         // watchdog on cycles without any handshake
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic [skit_pkg::KEY_W-1:0] pool [40];
      int r;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.opcode = skit_pkg::OP_LOOKUP;
      req_if.key = '0;
      req_if.record_position = '0;
      rsp_if.ready = 1'b0;
      tbl_count = 0;
      req_taken = 1'b0;
      burst_left = 0;
      gap_left = 0;
      stall_left = 0;
      mode_cycles = 0;
      ready_mode = 0;

      // Directed: empty table, extremes, duplicates, front/back/middle moves, unused code
      add_request(skit_pkg::OP_LOOKUP, 31'd5, 31'd0);
      add_request(skit_pkg::OP_DELETE, 31'd5, 31'd0);
      add_request(OP_UNUSED, 31'h7FFFFFFF, 31'h7FFFFFFF);
      add_request(skit_pkg::OP_INSERT, 31'd0, 31'h7FFFFFFF);
      add_request(skit_pkg::OP_INSERT, 31'h7FFFFFFF, 31'd0);
      add_request(skit_pkg::OP_INSERT, 31'h40000000, 31'h2AAAAAAA);
      add_request(skit_pkg::OP_INSERT, 31'h15555555, 31'h55555555);
      add_request(skit_pkg::OP_INSERT, 31'd0, 31'd1234);
      add_request(skit_pkg::OP_LOOKUP, 31'd0, 31'd0);
      add_request(skit_pkg::OP_LOOKUP, 31'h7FFFFFFF, 31'd0);
      add_request(skit_pkg::OP_LOOKUP, 31'h15555555, 31'd0);
      add_request(skit_pkg::OP_LOOKUP, 31'd1, 31'd0);
      add_request(skit_pkg::OP_INSERT, 31'd1, 31'h0F0F0F0F);
      add_request(skit_pkg::OP_DELETE, 31'h7FFFFFFF, 31'd0);
      add_request(skit_pkg::OP_DELETE, 31'd0, 31'd0);
      add_request(skit_pkg::OP_DELETE, 31'd0, 31'd0);
      add_request(skit_pkg::OP_LOOKUP, 31'd1, 31'd0);
      add_request(skit_pkg::OP_DELETE, 31'h40000000, 31'd0);
      add_request(OP_UNUSED, 31'd0, 31'd0);

      // Churn on a small key pool: many hits, duplicates and misses
      pool[0] = 31'd0;
      pool[1] = 31'h7FFFFFFF;
      for (int i = 2; i < 40; i++) pool[i] = rand31();
      for (int i = 0; i < 300; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            add_request(OP_UNUSED, rand31(), rand31());
         else if (r < 40)
            add_request(skit_pkg::OP_INSERT, pool[$urandom_range(0, 39)], rand31());
         else if (r < 65)
            add_request(skit_pkg::OP_DELETE, ($urandom_range(0, 9) == 0) ? rand31()
                        : pool[$urandom_range(0, 39)], rand31());
         else
            add_request(skit_pkg::OP_LOOKUP, ($urandom_range(0, 9) == 0) ? rand31()
                        : pool[$urandom_range(0, 39)], rand31());
      end

      // Fill the table with fresh keys until it runs full
      for (int i = 0; i < 340; i++) begin
         if ($urandom_range(0, 99) < 85)
            add_request(skit_pkg::OP_INSERT, rand31(), rand31());
         else
            add_request(skit_pkg::OP_LOOKUP, pick_issued(0), rand31());
      end

      // Hold at full: rejected inserts, duplicates and lookups
      for (int i = 0; i < 40; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) add_request(skit_pkg::OP_INSERT, rand31(), rand31());
         else if (r < 70) add_request(skit_pkg::OP_INSERT, pick_issued(0), rand31());
         else if (r < 90) add_request(skit_pkg::OP_LOOKUP, pick_issued(0), rand31());
         else add_request(skit_pkg::OP_LOOKUP, rand31(), rand31());
      end

      // Drain: mostly deletes of present keys
      for (int i = 0; i < 340; i++) begin
         r = $urandom_range(0, 99);
         if (r < 75) add_request(skit_pkg::OP_DELETE, pick_issued(1), rand31());
         else if (r < 85) add_request(skit_pkg::OP_LOOKUP, pick_issued(0), rand31());
         else if (r < 93) add_request(skit_pkg::OP_INSERT, rand31(), rand31());
         else add_request(skit_pkg::OP_DELETE, rand31(), rand31());
      end

      // Mixed traffic over the whole key range
      for (int i = 0; i < 380; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            add_request(OP_UNUSED, rand31(), rand31());
         else if (r < 45)
            add_request(skit_pkg::OP_INSERT,
                        ($urandom_range(0, 4) < 2) ? pick_issued(0) : rand31(), rand31());
         else if (r < 70)
            add_request(skit_pkg::OP_DELETE,
                        ($urandom_range(0, 4) < 3) ? pick_issued(1) : rand31(), rand31());
         else
            add_request(skit_pkg::OP_LOOKUP,
                        ($urandom_range(0, 4) < 3) ? pick_issued(0) : rand31(), rand31());
      end

      // Release reset on a falling clock edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every result to arrive
      while (!(accepted_count == total_requests && pending_results.size() == 0))
         @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Run covered %0d requests and %0d results, peak occupancy %0d of %0d.",
               accepted_count, result_count, peak_count, skit_pkg::TABLE_DEPTH);
      $display("Inserts ok %0d, duplicate %0d, full %0d; deletes ok %0d; lookup hits %0d;",
               insert_ok, insert_dup, insert_full, delete_ok, lookup_hit);
      $display("Misses %0d.", miss_count);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
